// ===== hw/rtl/salc_pkg.sv =====
`timescale 1ns / 1ps

package salc_pkg;

   // Cache geometry
   localparam int ADDR_BITS  = 32;
   localparam int NUM_SETS   = 64;
   localparam int NUM_WAYS   = 4;
   localparam int LINE_BYTES = 16;

   // Field widths (floor of log2 for sizes that are not powers of two)
   localparam int OFFSET_BITS = $clog2(LINE_BYTES + 1) - 1;
   localparam int SET_BITS    = $clog2(NUM_SETS + 1) - 1;
   localparam int TAG_LEN     = (ADDR_BITS > OFFSET_BITS + SET_BITS) ?
                                (ADDR_BITS - OFFSET_BITS - SET_BITS) : 0;

   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int TAG_W = (TAG_LEN > 0) ? TAG_LEN : 1;
   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

   // Request field widths
   localparam int REQ_ADDR_W = 32;
   localparam int RSP_WAY_W  = 2;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [SET_W-1:0]     set_type;
   typedef logic [TAG_W-1:0]     tag_type;
   typedef logic [WAY_W-1:0]     way_type;

   localparam addr_type SET_MASK = addr_type'((64'd1 << SET_BITS) - 64'd1);
   localparam addr_type TAG_SEL  = addr_type'((64'd1 << TAG_LEN) - 64'd1);

   // Most recently used rank
   localparam way_type RANK_MRU = way_type'(NUM_WAYS - 1);

   // One set as held in the row memory
   typedef struct packed {
      logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
      logic [NUM_WAYS-1:0]            dirty;
      logic [NUM_WAYS-1:0][WAY_W-1:0] rank;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   // Outcome of one lookup
   typedef struct packed {
      logic    hit;
      logic    evicted;
      logic    writeback;
      way_type way;
   } result_type;

endpackage

// ===== hw/rtl/salc_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port, one registered read port
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read of the old contents on an address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/salc_lookup.sv =====
`timescale 1ns / 1ps

// Tag compare, victim choice and row update for one set
module salc_lookup (
   input  salc_pkg::row_type                 row_in,
   input  logic [salc_pkg::NUM_WAYS-1:0]     valid_in,
   input  salc_pkg::tag_type                 tag_in,
   input  logic                              is_write,
   output salc_pkg::row_type                 row_out,
   output logic [salc_pkg::NUM_WAYS-1:0]     valid_out,
   output salc_pkg::result_type              result
);

   logic [salc_pkg::NUM_WAYS-1:0] match;
   logic                          hit;
   logic                          full;
   salc_pkg::way_type             hit_way;
   salc_pkg::way_type             free_way;
   salc_pkg::way_type             lru_way;
   salc_pkg::way_type             way;
   salc_pkg::way_type             old_rank;

   // Compare every way of the set side by side
   always_comb begin
      for (int i = 0; i < salc_pkg::NUM_WAYS; i++) begin
         match[i] = valid_in[i] && (row_in.tag[i] == tag_in);
      end
   end

   assign hit  = |match;
   assign full = &valid_in;

   // Lowest-numbered matching, free and least recent ways
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      lru_way  = '0;
      for (int i = salc_pkg::NUM_WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_way = salc_pkg::way_type'(i);
         end
         if (!valid_in[i]) begin
            free_way = salc_pkg::way_type'(i);
         end
         // ranks of a full set form a permutation, so rank zero is the minimum
         if (row_in.rank[i] == '0) begin
            lru_way = salc_pkg::way_type'(i);
         end
      end
   end

   assign way      = hit ? hit_way : (full ? lru_way : free_way);
   assign old_rank = row_in.rank[way];

   // New contents of the set
   always_comb begin
      row_out   = row_in;
      valid_out = valid_in;
      for (int i = 0; i < salc_pkg::NUM_WAYS; i++) begin
         if (salc_pkg::way_type'(i) == way) begin
            row_out.rank[i] = salc_pkg::RANK_MRU;
            valid_out[i]    = 1'b1;
            if (hit) begin
               row_out.dirty[i] = row_in.dirty[i] | is_write;
            end else begin
               row_out.dirty[i] = is_write;
               row_out.tag[i]   = tag_in;
            end
         end else if (row_in.rank[i] > old_rank) begin
            row_out.rank[i] = row_in.rank[i] - salc_pkg::way_type'(1);
         end
      end
   end

   // Outcome
   always_comb begin
      result.hit       = hit;
      result.evicted   = !hit && full;
      result.writeback = !hit && full && row_in.dirty[way];
      result.way       = way;
   end

endmodule

// ===== hw/rtl/set_assoc_lru_cache_tags_top.sv =====
`timescale 1ns / 1ps

// Channel    Ports                                          Transfer
// ---------  ---------------------------------------------  -----------------------------
// request    start, busy, req_mode, req_address             start && !busy at clock edge
// response   rsp_strobe, rsp_hit, rsp_evicted,              one-cycle strobe, no stall
//            rsp_writeback, rsp_way_used
//
// One access is taken every cycle; busy stays low.
// Pipeline: at the accepting edge the set row is read from memory and the request is
// registered into the lookup stage, where the lookup and row write happen; the result
// strobes from the response register. Back-to-back accesses to one set are forwarded
// around the memory. Reset clears the per-way valid flops directly; no clearing sweep
// is needed. The receiver cannot stall; each result is shown for one cycle only.
module set_assoc_lru_cache_tags_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic [salc_pkg::REQ_ADDR_W-1:0]     req_address,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic                                rsp_evicted,
   output logic                                rsp_writeback,
   output logic [salc_pkg::RSP_WAY_W-1:0]      rsp_way_used
);

   logic                  accept;
   salc_pkg::addr_type    addr_ext;
   salc_pkg::set_type     req_set;
   salc_pkg::tag_type     req_tag;

   logic                  s1_valid_ff, s1_valid_in;
   salc_pkg::set_type     s1_set_ff;
   salc_pkg::tag_type     s1_tag_ff;
   logic                  s1_write_ff;
   logic                  fwd_sel_ff, fwd_sel_in;
   salc_pkg::row_type     fwd_row_ff;

   logic [salc_pkg::NUM_WAYS-1:0] valid_ff [salc_pkg::NUM_SETS];
   logic [salc_pkg::NUM_WAYS-1:0] valid_vec;
   logic [salc_pkg::NUM_WAYS-1:0] valid_new;

   logic [salc_pkg::ROW_W-1:0] ram_rd_data;
   salc_pkg::row_type          row_cur;
   salc_pkg::row_type          row_new;
   salc_pkg::result_type       res;

   logic                  rsp_strobe_ff;
   salc_pkg::result_type  rsp_ff;

   // Request decode
   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign addr_ext = salc_pkg::addr_type'(req_address);
   assign req_set  = salc_pkg::set_type'((addr_ext >> salc_pkg::OFFSET_BITS)
                                         & salc_pkg::SET_MASK);
   assign req_tag  = salc_pkg::tag_type'((addr_ext >> (salc_pkg::OFFSET_BITS
                                         + salc_pkg::SET_BITS)) & salc_pkg::TAG_SEL);

   // Row memory: tags, dirty marks and ranks of each set
   salc_ram #(
      .WIDTH (salc_pkg::ROW_W),
      .DEPTH (salc_pkg::NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_set_ff),
      .wr_data (row_new),
      .rd_addr (req_set),
      .rd_data (ram_rd_data)
   );

   // Current row: forwarded from the previous access or read from memory;
   // a set with no valid way reads as all zeros
   assign valid_vec = valid_ff[s1_set_ff];

   always_comb begin
      if (fwd_sel_ff) begin
         row_cur = fwd_row_ff;
      end else begin
         row_cur = salc_pkg::row_type'(ram_rd_data);
      end
      if (valid_vec == '0) begin
         row_cur = '0;
      end
   end

   salc_lookup u_lookup (
      .row_in    (row_cur),
      .valid_in  (valid_vec),
      .tag_in    (s1_tag_ff),
      .is_write  (s1_write_ff),
      .row_out   (row_new),
      .valid_out (valid_new),
      .result    (res)
   );

   // Lookup stage control
   assign s1_valid_in = accept;
   assign fwd_sel_in  = accept && s1_valid_ff && (s1_set_ff == req_set);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fwd_sel_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fwd_sel_ff    <= fwd_sel_in;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   // Lookup stage and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_set_ff   <= req_set;
         s1_tag_ff   <= req_tag;
         s1_write_ff <= req_mode;
      end
      if (s1_valid_ff) begin
         fwd_row_ff <= row_new;
         rsp_ff     <= res;
      end
   end

   // Per-way valid marks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < salc_pkg::NUM_SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else if (s1_valid_ff) begin
         valid_ff[s1_set_ff] <= valid_new;
      end
   end

   // Result ports
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_hit       = rsp_ff.hit;
   assign rsp_evicted   = rsp_ff.evicted;
   assign rsp_writeback = rsp_ff.writeback;
   assign rsp_way_used  = salc_pkg::RSP_WAY_W'(rsp_ff.way);

`ifndef ASSERT_OFF
   // Every accepted transaction strobes a result after the lookup stage and the response register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("accepted transaction produced no result");

   // A write-back only comes with an eviction on a miss
   a_wb_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_writeback) |-> (rsp_evicted && !rsp_hit))
      else $error("write-back without eviction");

   // Eviction only happens from a full set
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && res.evicted) |-> (valid_vec == '1))
      else $error("eviction from a set with a free way");

   // Forwarding only follows a lookup in the previous cycle
   a_fwd: assert property (@(posedge clock) disable iff (reset)
      fwd_sel_ff |-> (s1_valid_ff && $past(s1_valid_ff)))
      else $error("row forwarded without a preceding lookup");
`endif

endmodule
